@@ hdl/prim_mst_pkg.sv @@
`timescale 1ns / 1ps
package prim_mst_pkg;

	localparam int NODE_W        = 4;
	localparam int TIME_W        = 16;
	localparam int SUM_W         = 20;
	localparam int CFG_W         = 5;
	localparam int DEF_MAX_NODES = 16;
	localparam int DEF_TIME_BITS = 16;
	localparam int MIN_NODES     = 2;
	localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(16);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

endpackage

@@ hdl/prim_mst_ram.sv @@
`timescale 1ns / 1ps
module prim_mst_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem_q [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/prim_minimum_spanning_tree_top.sv @@
`timescale 1ns / 1ps
// a matrix entry without last_entry is taken and busy stays low
// a run takes up to n-1 steps, n the clamped node count; each step
// reads every matrix pair once through the single read port of the matrix ram
// results show for one cycle on result_valid, the receiver cannot stall them
// reset clears control state and sets node_count to 16; the matrix is undefined
// until written and keeps its contents between runs
module prim_minimum_spanning_tree_top #(
	parameter int MAX_NODES = prim_mst_pkg::DEF_MAX_NODES,
	parameter int TIME_BITS = prim_mst_pkg::DEF_TIME_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [prim_mst_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                              start,
	output logic                              busy,
	input  logic [prim_mst_pkg::NODE_W-1:0]   row_node,
	input  logic [prim_mst_pkg::NODE_W-1:0]   col_node,
	input  logic [prim_mst_pkg::TIME_W-1:0]   travel_time,
	input  logic                              last_entry,
	output logic                              result_valid,
	output logic [prim_mst_pkg::NODE_W-1:0]   edge_from,
	output logic [prim_mst_pkg::NODE_W-1:0]   edge_to,
	output logic [prim_mst_pkg::TIME_W-1:0]   edge_time,
	output logic [prim_mst_pkg::SUM_W-1:0]    total_time,
	output logic                              disconnected,
	output logic                              last_edge
);
	import prim_mst_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int AW = 2 * NW;
	localparam logic [TIME_BITS-1:0] NO_EDGE = {TIME_BITS{1'b1}};

	state_t state_q;

	logic [CFG_W-1:0]     node_count_q;
	logic [CW-1:0]        n_q;
	logic [CW-1:0]        n_m1;
	logic [CW-1:0]        n_start;
	logic [NW-1:0]        i_q;
	logic [NW-1:0]        j_q;
	logic [NW-1:0]        i_s1;
	logic [NW-1:0]        j_s1;
	logic                 vld_s1;
	logic [MAX_NODES-1:0] mask_q;
	logic [CW-1:0]        edges_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SUM_W-1:0]     sum_next;
	logic [TIME_BITS-1:0] best_q;
	logic [NW-1:0]        bi_q;
	logic [NW-1:0]        bj_q;
	logic                 found_q;
	logic                 accept;
	logic                 in_range;
	logic                 last_pair;
	logic                 take;
	logic [TIME_BITS-1:0] rdata;
	logic [NW-1:0]        wr_row;
	logic [NW-1:0]        wr_col;

	logic                 result_valid_q;
	logic [NODE_W-1:0]    edge_from_q;
	logic [NODE_W-1:0]    edge_to_q;
	logic [TIME_W-1:0]    edge_time_q;
	logic [SUM_W-1:0]     total_time_q;
	logic                 disconnected_q;
	logic                 last_edge_q;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign in_range = (32'(row_node) < MAX_NODES) && (32'(col_node) < MAX_NODES);
	assign wr_row   = NW'(row_node);
	assign wr_col   = NW'(col_node);

	always_comb begin
		if (32'(node_count_q) < MIN_NODES) begin
			n_start = CW'(MIN_NODES);
		end else if (32'(node_count_q) > MAX_NODES) begin
			n_start = CW'(MAX_NODES);
		end else begin
			n_start = CW'(node_count_q);
		end
	end

	assign n_m1      = n_q - CW'(1);
	assign last_pair = (CW'(i_q) == n_m1) && (CW'(j_q) == n_m1);
	assign sum_next  = sum_q + SUM_W'(best_q);

	// shared compare unit
	assign take = vld_s1 && mask_q[i_s1] && !mask_q[j_s1] && (rdata != '0)
		&& (rdata != NO_EDGE) && (rdata < best_q);

	prim_mst_ram #(
		.ADDR_W(AW),
		.DATA_W(TIME_BITS)
	) u_ram (
		.clk  (clk),
		.we   (accept && in_range),
		.waddr({wr_row, wr_col}),
		.wdata(TIME_BITS'(travel_time)),
		.raddr({i_q, j_q}),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			n_q            <= CW'(MIN_NODES);
			i_q            <= '0;
			j_q            <= '0;
			i_s1           <= '0;
			j_s1           <= '0;
			vld_s1         <= 1'b0;
			mask_q         <= '0;
			edges_q        <= '0;
			sum_q          <= '0;
			best_q         <= NO_EDGE;
			bi_q           <= '0;
			bj_q           <= '0;
			found_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			vld_s1         <= 1'b0;
			i_s1           <= i_q;
			j_s1           <= j_q;
			if (take) begin
				best_q  <= rdata;
				bi_q    <= i_s1;
				bj_q    <= j_s1;
				found_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && last_entry) begin
						n_q     <= n_start;
						mask_q  <= MAX_NODES'(1);
						edges_q <= '0;
						sum_q   <= '0;
						best_q  <= NO_EDGE;
						found_q <= 1'b0;
						i_q     <= '0;
						j_q     <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					vld_s1 <= 1'b1;
					if (last_pair) begin
						state_q <= ST_DRAIN;
					end else if (CW'(j_q) == n_m1) begin
						j_q <= '0;
						i_q <= i_q + NW'(1);
					end else begin
						j_q <= j_q + NW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					result_valid_q <= 1'b1;
					i_q            <= '0;
					j_q            <= '0;
					best_q         <= NO_EDGE;
					found_q        <= 1'b0;
					if (!found_q) begin
						state_q <= ST_IDLE;
					end else begin
						mask_q[bj_q] <= 1'b1;
						edges_q      <= edges_q + CW'(1);
						sum_q        <= sum_next;
						if (edges_q + CW'(1) == n_m1) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			if (!found_q) begin
				edge_from_q    <= '0;
				edge_to_q      <= '0;
				edge_time_q    <= '0;
				total_time_q   <= sum_q;
				disconnected_q <= 1'b1;
				last_edge_q    <= 1'b1;
			end else begin
				edge_from_q    <= NODE_W'(bi_q);
				edge_to_q      <= NODE_W'(bj_q);
				edge_time_q    <= TIME_W'(best_q);
				total_time_q   <= sum_next;
				disconnected_q <= 1'b0;
				last_edge_q    <= (edges_q + CW'(1) == n_m1);
			end
		end
	end

	assign result_valid = result_valid_q;
	assign edge_from    = edge_from_q;
	assign edge_to      = edge_to_q;
	assign edge_time    = edge_time_q;
	assign total_time   = total_time_q;
	assign disconnected = disconnected_q;
	assign last_edge    = last_edge_q;

	a_disc_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && disconnected |-> last_edge)
		else $error("disconnected result not marked last");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_EMIT))
		else $error("result without emit step");

	a_done_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid && last_edge)
		else $error("run ended without final result");

	a_root_in_tree: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> mask_q[0])
		else $error("root node missing from tree");

endmodule
